// File: src/itrt_pkg.sv
package itrt_pkg;

  localparam int DEFAULT_NUMBER_WIDTH = 32;
  localparam int MAX_SYMBOLS          = 16;
  localparam int SYM_COUNT            = 16;
  localparam int SYM_W                = 8;
  localparam int DIGIT_W              = 4;
  localparam int RADIX_W              = 5;
  localparam int CFG_DATA_W           = 64;
  localparam int CFG_IDX_W            = 2;
  localparam int QUEUE_DEPTH          = 2;
  // division steps done per cycle in the back end
  localparam int DIV_STEPS            = 8;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX        = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RADIX_W-1:0]                radix;
    logic [SYM_COUNT-1:0][SYM_W-1:0]   symbols;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SIGN,
    BK_DIGITS
  } back_state_e;

endpackage

// File: src/integer_to_radix_text.sv
// Converts one signed NUMBER_WIDTH-bit number per input item into a stream of
// characters in the configured radix (2 to 16), one character per output item:
// a '-' first for a negative number, then the digit symbols most significant
// first, with last_o set on the final one. The magnitude is taken as unsigned,
// so the most negative value converts in every radix. Program radix and the two
// symbol words through the write port while the block is idle; if the radix is
// below 2 or above 16, or a symbol in use is 0x00, '+', '-', or repeated, items
// are accepted and produce no output. A front end takes and checks items into a
// two-entry queue; a back end divides by the radix at eight quotient bits per
// cycle, repeating the full division for each digit, then plays the digits
// back one per cycle from a stack while the output is not stalled.
module integer_to_radix_text #(
  parameter int NUMBER_WIDTH = itrt_pkg::DEFAULT_NUMBER_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [itrt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [itrt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // number input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [NUMBER_WIDTH-1:0]          number_i,
  // character output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [itrt_pkg::SYM_W-1:0]       character_o,
  output logic                             last_o
);
  import itrt_pkg::*;

  cfg_t                  cfg_q;
  logic                  q_push, q_full, q_pop, q_empty;
  logic [NUMBER_WIDTH:0] q_wdata, q_rdata;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RADIX:        cfg_q.radix                 <= cfg_data_i[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  cfg_q.symbols[7:0]          <= cfg_data_i;
        REG_SYMBOLS_HIGH: cfg_q.symbols[SYM_COUNT-1:8] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept, check the table, form sign and magnitude
  itrt_front #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .number_i   (number_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // queue of pending numbers between front and back
  itrt_fifo #(
    .WIDTH (NUMBER_WIDTH + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  // back: digit extraction and character playback
  itrt_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: src/itrt_front.sv
module itrt_front #(
  parameter int NUMBER_WIDTH = itrt_pkg::DEFAULT_NUMBER_WIDTH
) (
  input  itrt_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [NUMBER_WIDTH-1:0]   number_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output logic [NUMBER_WIDTH:0]     q_data_o
);
  import itrt_pkg::*;

  logic                    table_ok;
  logic                    neg;
  logic [NUMBER_WIDTH-1:0] mag;

  // table check: radix range, no reserved or repeated symbol among those in use
  always_comb begin : table_check
    logic bad;
    bad = (cfg_i.radix < RADIX_W'(2)) || (cfg_i.radix > RADIX_W'(MAX_SYMBOLS));
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (RADIX_W'(i) < cfg_i.radix) begin
        if (cfg_i.symbols[i] == CHAR_NUL || cfg_i.symbols[i] == CHAR_PLUS ||
            cfg_i.symbols[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (cfg_i.symbols[j] == cfg_i.symbols[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
    table_ok = !bad;
  end

  // unsigned magnitude, so the most negative value converts too
  assign neg = number_i[NUMBER_WIDTH-1];
  assign mag = neg ? (~number_i + NUMBER_WIDTH'(1)) : number_i;

  // items with a bad table are accepted and dropped
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && table_ok;
  assign q_data_o   = {neg, mag};

endmodule

// File: src/itrt_fifo.sv
module itrt_fifo #(
  parameter int WIDTH = itrt_pkg::DEFAULT_NUMBER_WIDTH + 1,
  parameter int DEPTH = itrt_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/itrt_back.sv
module itrt_back #(
  parameter int NUMBER_WIDTH = itrt_pkg::DEFAULT_NUMBER_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrt_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  logic [NUMBER_WIDTH:0]         q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itrt_pkg::SYM_W-1:0]    character_o,
  output logic                          last_o
);
  import itrt_pkg::*;

  localparam int CW = $clog2(NUMBER_WIDTH + 1);
  localparam int IW = $clog2(NUMBER_WIDTH);

  back_state_e state_q, state_d;

  logic [NUMBER_WIDTH-1:0] work_q, work_d, div_work;
  logic [DIGIT_W-1:0]      rem_q, rem_d, div_rem;
  logic [CW-1:0]           bits_left_q, bits_left_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    neg_q, neg_d;
  logic                    div_last;
  logic                    digit_we;
  logic [IW-1:0]           rd_idx;
  logic [DIGIT_W-1:0]      digit_q;

  logic [DIGIT_W-1:0]      digit_stack [NUMBER_WIDTH];

  logic                    out_free, out_load;
  logic                    out_valid_q, out_valid_d;
  logic [SYM_W-1:0]        out_char_q, out_char_d;
  logic                    out_last_q, out_last_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (bits_left_q <= CW'(DIV_STEPS));
  // read ahead at the next top of stack, so digit_q holds the top entry
  assign rd_idx   = IW'(count_d - CW'(1));

  // restoring division by the radix, several quotient bits per cycle
  always_comb begin : div_step
    logic [DIGIT_W:0] t;
    div_rem  = rem_q;
    div_work = work_q;
    t        = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (CW'(i) < bits_left_q) begin
        t = {div_rem, div_work[NUMBER_WIDTH-1]};
        if (t >= cfg_i.radix) begin
          div_rem  = DIGIT_W'(t - cfg_i.radix);
          div_work = {div_work[NUMBER_WIDTH-2:0], 1'b1};
        end else begin
          div_rem  = t[DIGIT_W-1:0];
          div_work = {div_work[NUMBER_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (div_last && div_work == '0) state_d = neg_q ? BK_SIGN : BK_DIGITS;
      end
      BK_SIGN: begin
        if (out_free) state_d = BK_DIGITS;
      end
      BK_DIGITS: begin
        if (out_free && count_q == CW'(1)) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin : datapath
    q_pop_o     = 1'b0;
    work_d      = work_q;
    rem_d       = rem_q;
    bits_left_d = bits_left_q;
    count_d     = count_q;
    neg_d       = neg_q;
    digit_we    = 1'b0;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          neg_d       = q_data_i[NUMBER_WIDTH];
          work_d      = q_data_i[NUMBER_WIDTH-1:0];
          rem_d       = '0;
          bits_left_d = CW'(NUMBER_WIDTH);
          count_d     = '0;
        end
      end
      BK_DIVIDE: begin
        work_d = div_work;
        if (div_last) begin
          digit_we    = 1'b1;
          count_d     = count_q + CW'(1);
          rem_d       = '0;
          bits_left_d = CW'(NUMBER_WIDTH);
        end else begin
          rem_d       = div_rem;
          bits_left_d = bits_left_q - CW'(DIV_STEPS);
        end
      end
      BK_SIGN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = CHAR_MINUS;
          out_last_d = 1'b0;
        end
      end
      BK_DIGITS: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = cfg_i.symbols[digit_q];
          out_last_d = (count_q == CW'(1));
          count_d    = count_q - CW'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      bits_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bits_left_q <= bits_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    // a new digit lands on top of the stack and is passed straight through
    if (digit_we) begin
      digit_stack[count_q[IW-1:0]] <= div_rem;
      digit_q                      <= div_rem;
    end else begin
      digit_q                      <= digit_stack[rd_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // digit count never runs past the stack
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIVIDE |-> count_q < CW'(NUMBER_WIDTH))
    else $error("digit stack overflow");

  // partial remainder stays below the radix
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIVIDE |-> {1'b0, rem_q} < cfg_i.radix)
    else $error("remainder out of range");

  // every number ends with its stack drained
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> count_q == '0)
    else $error("digits left over at idle");

  // the final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_last_d |=> state_q == BK_IDLE && out_valid_q && out_last_q)
    else $error("last character without return to idle");
`endif

endmodule
